// File: sv/rpn_pkg.sv
// Shared types, codes and helpers for the postfix expression evaluator.
// Used by rpn_alu, postfix_expression_evaluator_unit and its testbench; depends on nothing.
`default_nettype none

package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int ITER_W          = 5;   // counts the 32 steps of multiply and divide
  localparam int IN_TDATA_W      = 40;  // op (3) + value (32), padded to whole bytes
  localparam int OUT_TDATA_W     = 32;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_MUL  = 3'd1,
    OP_DIV  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_DIVZERO   = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_R,
    S_POP_L,
    S_EXEC,
    S_WAIT,
    S_FIN_POP,
    S_FIN_OUT
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

  // The first error of an expression is kept; later ones are ignored.
  function automatic err_t note_err(err_t cur, err_t code);
    note_err = (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

`default_nettype wire

// File: sv/postfix_expression_evaluator_unit.sv
// Top level of the postfix expression evaluator: token sequencer, operand
// stack memory and output register. Depends on rpn_pkg and rpn_alu.
//
//  channel | direction | tdata                        | tuser       | tlast
//  in_     | slave     | [2:0] op, [34:3] value       | -           | last
//  out_    | master    | [31:0] result                | [1:0] status| -
//
// A push is taken in S_IDLE and the block stays ready for the next token.
// An operator passes through acceptance, the two pops and the unit start,
// then waits on the unit in S_WAIT: add, subtract and divide by zero raise
// done from the start itself, multiply and divide after 32 steps of one bit.
// A last word adds the final pop and output, plus any wait on out_tready.
// Reset clears the stack count, error and output valid, not the stack memory.
`default_nettype none

module postfix_expression_evaluator_unit
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] op, [34:3] value, rest zero
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [31:0] result
  output logic      [STATUS_W-1:0]    out_tuser   // [1:0] status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  err_t              err_r, err_nxt;
  logic              popz_r, popz_nxt;     // last pop found the stack empty
  op_t               op_r, op_nxt;
  logic              last_r, last_nxt;
  logic [DATA_W-1:0] right_r, right_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  err_t              out_status_r, out_status_nxt;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic              accept, emit, pop_go, push_go;
  logic [DATA_W-1:0] push_data, popped;
  logic [CW-1:0]     cnt_dec;
  logic [2:0]        in_op;
  logic [DATA_W-1:0] in_value;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] alu_a, alu_result;

  assign in_op    = in_tdata[2:0];
  assign in_value = in_tdata[DATA_W+2:3];
  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign popped   = popz_r ? '0 : rd_data_r;
  assign cnt_dec  = cnt_r - CW'(1);
  assign emit     = (state_r == S_FIN_OUT) && (!out_valid_r || out_tready);

  rpn_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (alu_a),
    .b      (right_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_MUL || in_op == OP_DIV || in_op == OP_ADD || in_op == OP_SUB)
            state_nxt = S_POP_R;
          else if (in_tlast)
            state_nxt = S_FIN_POP;
        end
      end
      S_POP_R:   state_nxt = S_POP_L;
      S_POP_L:   state_nxt = S_EXEC;
      S_EXEC:    state_nxt = S_WAIT;
      S_WAIT: begin
        if (alu_rsp.done) state_nxt = last_r ? S_FIN_POP : S_IDLE;
      end
      S_FIN_POP: state_nxt = S_FIN_OUT;
      S_FIN_OUT: begin
        if (emit) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and stack control.
  always_comb begin
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    popz_nxt       = popz_r;
    op_nxt         = op_r;
    last_nxt       = last_r;
    right_nxt      = right_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    pop_go         = 1'b0;
    push_go        = 1'b0;
    push_data      = in_value;
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;
    alu_a          = popped;
    rd_en          = 1'b0;
    rd_addr        = cnt_dec[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = cnt_r[AW-1:0];
    wr_data        = push_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_tlast;
          op_nxt   = op_t'(in_op);
          push_go  = (in_op == OP_PUSH);
        end
      end
      S_POP_R: pop_go = 1'b1;
      S_POP_L: begin
        right_nxt = popped;
        pop_go    = 1'b1;
      end
      S_EXEC: alu_req.start = 1'b1;
      S_WAIT: begin
        if (alu_rsp.done) begin
          if (alu_rsp.div0) err_nxt = note_err(err_nxt, ERR_DIVZERO);
          push_go   = 1'b1;
          push_data = alu_result;
        end
      end
      S_FIN_POP: pop_go = 1'b1;
      S_FIN_OUT: begin
        if (emit) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = popped;
          out_status_nxt = err_r;
          cnt_nxt        = '0;
          err_nxt        = ERR_NONE;
        end
      end
      default: ;
    endcase

    if (pop_go) begin
      if (cnt_r == '0) begin
        popz_nxt = 1'b1;
        err_nxt  = note_err(err_nxt, ERR_UNDERFLOW);
      end else begin
        popz_nxt = 1'b0;
        cnt_nxt  = cnt_dec;
        rd_en    = 1'b1;
      end
    end

    if (push_go) begin
      if (cnt_r >= CW'(STACK_DEPTH)) begin
        err_nxt = note_err(err_nxt, ERR_OVERFLOW);
      end else begin
        wr_en   = 1'b1;
        wr_data = push_data;
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popz_r       <= popz_nxt;
    op_r         <= op_nxt;
    last_r       <= last_nxt;
    right_r      <= right_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= stack_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r) == S_FIN_OUT)
    else $error("result word raised outside the final state");

  a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_WAIT)
    else $error("arithmetic unit finished while not awaited");

  a_first_err_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE && !emit) |=> $stable(err_r))
    else $error("recorded error replaced");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_MUL || in_op == OP_DIV || in_op == OP_ADD || in_op == OP_SUB))
      |=> !in_tready)
    else $error("ready while an operator is in work");

endmodule

`default_nettype wire

// File: sv/rpn_alu.sv
// Shared arithmetic unit: add and subtract, bit-serial multiply
// and restoring divide. Depends on rpn_pkg.
`default_nettype none

module rpn_alu
  import rpn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire alu_req_t          req,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [DATA_W-1:0] b,
  output alu_rsp_t               rsp,
  output logic      [DATA_W-1:0] result
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              div0_r, div0_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  op_t               op_r, op_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;   // product sum, or dividend turning into quotient
  logic [DATA_W-1:0] ma_r, ma_nxt;     // shifted multiplicand
  logic [DATA_W-1:0] mb_r, mb_nxt;     // multiplier bits, or divisor magnitude
  logic [DATA_W-1:0] rem_r, rem_nxt;

  logic [DATA_W-1:0] a_mag, b_mag, rem_sh;
  logic [DATA_W:0]   trial;

  assign a_mag  = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
  assign b_mag  = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
  // The remainder stays below the divisor, at most 2^31, so its top bit is zero.
  assign rem_sh = {rem_r[DATA_W-2:0], acc_r[DATA_W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, mb_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div0_nxt = 1'b0;
    iter_nxt = iter_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      op_nxt   = req.op;
      neg_nxt  = 1'b0;
      iter_nxt = '0;
      unique case (req.op)
        OP_MUL: begin
          acc_nxt  = '0;
          ma_nxt   = a;
          mb_nxt   = b;
          busy_nxt = 1'b1;
        end
        OP_DIV: begin
          if (b == '0) begin
            acc_nxt  = '0;
            div0_nxt = 1'b1;
            done_nxt = 1'b1;
          end else begin
            acc_nxt  = a_mag;
            mb_nxt   = b_mag;
            rem_nxt  = '0;
            neg_nxt  = a[DATA_W-1] ^ b[DATA_W-1];
            busy_nxt = 1'b1;
          end
        end
        OP_ADD: begin
          acc_nxt  = a + b;
          done_nxt = 1'b1;
        end
        OP_SUB: begin
          acc_nxt  = a - b;
          done_nxt = 1'b1;
        end
        default: begin
          acc_nxt  = '0;
          done_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        if (mb_r[0]) acc_nxt = acc_r + ma_r;
        ma_nxt = {ma_r[DATA_W-2:0], 1'b0};
        mb_nxt = {1'b0, mb_r[DATA_W-1:1]};
      end else begin
        if (!trial[DATA_W]) begin
          rem_nxt = trial[DATA_W-1:0];
          acc_nxt = {acc_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          acc_nxt = {acc_r[DATA_W-2:0], 1'b0};
        end
      end
      iter_nxt = iter_r + ITER_W'(1);
      if (iter_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div0_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      div0_r <= div0_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.div0 = div0_r;
  // Divide works on magnitudes; the sign goes back on here. The most negative
  // quotient magnitude wraps to itself, as two's complement does.
  assign result   = neg_r ? (~acc_r + DATA_W'(1)) : acc_r;

endmodule

`default_nettype wire

// File: test/postfix_expression_evaluator_unit_tb.sv
// Self-checking testbench for postfix_expression_evaluator_unit: directed and random
// token streams, predicted against a behavioral stack evaluator and checked word by word.
// Depends on rpn_pkg and the evaluator RTL.

module postfix_expression_evaluator_unit_tb
  import rpn_pkg::*;
();

  localparam logic [2:0] OP_NOP5 = 3'd5;
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_TOKENS = 650;

  typedef struct {
    logic [2:0]        op;
    logic [DATA_W-1:0] value;
    logic              last;
  } token_t;

  typedef struct {
    logic [DATA_W-1:0] result;
    err_t              status;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  token_t   token_queue[$];
  outcome_t expected_results[$];
  token_t   next_token;
  int       tokens_queued = 0;
  int       tokens_sent = 0;
  int       errors = 0;
  int       stall_cycles = 0;
  logic     in_fire = 1'b0;

  // Behavioral copy of the evaluator state.
  logic [DATA_W-1:0] operand_mem [STACK_DEPTH_DEF];
  int unsigned       live_count = 0;
  err_t              expr_err = ERR_NONE;

  postfix_expression_evaluator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic void flag_error(err_t code);
    if (expr_err == ERR_NONE) expr_err = code;
  endfunction

  function automatic void push_operand(logic [DATA_W-1:0] v);
    if (live_count >= STACK_DEPTH_DEF) begin
      flag_error(ERR_OVERFLOW);
    end else begin
      operand_mem[live_count] = v;
      live_count++;
    end
  endfunction

  function automatic logic [DATA_W-1:0] pop_operand();
    if (live_count == 0) begin
      flag_error(ERR_UNDERFLOW);
      return '0;
    end
    live_count--;
    return operand_mem[live_count];
  endfunction

  // Applies one token; returns 1 with the emitted word when the token closes an expression.
  function automatic bit eval_token(input token_t tok, output outcome_t res);
    logic [DATA_W-1:0] rhs, lhs, r;
    longint quo;
    res.result = '0;
    res.status = ERR_NONE;
    if (tok.op == OP_PUSH) begin
      push_operand(tok.value);
    end else if (tok.op <= OP_SUB) begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (tok.op)
        OP_MUL: r = lhs * rhs;
        OP_DIV: begin
          if (rhs == '0) begin
            flag_error(ERR_DIVZERO);
            r = '0;
          end else begin
            // A 64-bit quotient keeps the most negative over minus one well defined.
            quo = longint'($signed(lhs)) / longint'($signed(rhs));
            r = quo[DATA_W-1:0];
          end
        end
        OP_ADD: r = lhs + rhs;
        default: r = lhs - rhs;
      endcase
      push_operand(r);
    end
    if (!tok.last) return 1'b0;
    res.result = pop_operand();
    res.status = expr_err;
    live_count = 0;
    expr_err = ERR_NONE;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4, 5: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_token(logic [2:0] op, logic [DATA_W-1:0] value, logic last);
    token_t t;
    t.op = op;
    t.value = value;
    t.last = last;
    token_queue.push_back(t);
    // Unused op codes without the last flag change nothing.
    if (op <= OP_SUB || last) tokens_queued++;
  endtask

  // Well-formed expression; with stack_first all operands are pushed before any operator.
  task automatic add_expression(int operands, bit stack_first);
    int pushed, live;
    pushed = 0;
    live = 0;
    while (pushed < operands || live > 1) begin
      if (pushed < operands && (live < 2 || stack_first || $urandom_range(0, 2) != 0)) begin
        add_token(OP_PUSH, pick_value(), 1'b0);
        pushed++;
        live++;
      end else begin
        add_token(3'($urandom_range(OP_MUL, OP_SUB)), $urandom, 1'b0);
        live--;
      end
    end
    token_queue[token_queue.size()-1].last = 1'b1;
  endtask

  function automatic bit idle_draw();
    if (tokens_sent >= 300 && tokens_sent < 450) return 1'b0;
    return $urandom_range(0, 99) < 13;
  endfunction

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (token_queue.size() > 0 && !idle_draw()) begin
          next_token = token_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_TDATA_W-DATA_W-3){1'b0}}, next_token.value, next_token.op};
          in_tlast <= next_token.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= !idle_draw();
    end
  end

  // Monitor, predictor and watchdog: everything is sampled on the rising edge.
  always @(posedge clk) begin : monitor
    outcome_t got_exp;
    outcome_t predicted;
    token_t   seen;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected word: result %h status %0d", out_tdata, out_tuser);
          errors++;
        end else begin
          got_exp = expected_results.pop_front();
          if (out_tdata !== got_exp.result) begin
            $error("result mismatch: expected %h, actual %h", got_exp.result, out_tdata);
            errors++;
          end
          if (out_tuser !== got_exp.status) begin
            $error("status mismatch: expected %0d, actual %0d", got_exp.status, out_tuser);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        seen.op = in_tdata[2:0];
        seen.value = in_tdata[DATA_W+2:3];
        seen.last = in_tlast;
        if (eval_token(seen, predicted)) expected_results.push_back(predicted);
        tokens_sent++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("postfix_expression_evaluator_unit_tb failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int mix;
    // Directed: wrapping, division corners, errors and unused op codes.
    add_token(OP_PUSH, 32'h7fff_ffff, 1'b0);
    add_token(OP_PUSH, 32'h0000_0001, 1'b0);
    add_token(OP_ADD, '0, 1'b1);
    add_token(OP_PUSH, 32'h8000_0000, 1'b0);
    add_token(OP_PUSH, 32'hffff_ffff, 1'b0);
    add_token(OP_DIV, '1, 1'b1);
    add_token(OP_PUSH, -32'sd7, 1'b0);
    add_token(OP_PUSH, 32'd2, 1'b0);
    add_token(OP_DIV, '0, 1'b1);
    add_token(OP_PUSH, 32'd3, 1'b0);
    add_token(OP_PUSH, '0, 1'b0);
    add_token(OP_DIV, '0, 1'b0);
    add_token(OP_SUB, '0, 1'b1);
    add_token(OP_PUSH, 32'h8000_0000, 1'b0);
    add_token(OP_PUSH, 32'h0000_0001, 1'b0);
    add_token(OP_SUB, '0, 1'b0);
    add_token(OP_PUSH, 32'h8000_0000, 1'b0);
    add_token(OP_MUL, '1, 1'b1);
    add_token(OP_NOP5, 32'h1234_5678, 1'b1);
    add_token(OP_NOP6, '1, 1'b0);
    add_token(OP_PUSH, 32'd9, 1'b0);
    add_token(OP_NOP7, '0, 1'b1);
    add_token(OP_ADD, '0, 1'b1);
    add_token(OP_PUSH, 32'hffff_fffe, 1'b1);

    while (tokens_queued < RANDOM_TOKENS) begin
      mix = $urandom_range(0, 99);
      if (mix <= 5) begin
        add_expression($urandom_range(30, 36), 1'b1);
      end else if (mix <= 20) begin
        add_expression($urandom_range(9, 20), 1'b0);
      end else if (mix <= 74) begin
        add_expression($urandom_range(1, 8), 1'b0);
      end else begin
        add_token(3'($urandom_range(OP_PUSH, OP_NOP7)), pick_value(),
                  $urandom_range(0, 3) == 0);
      end
    end
    token_queue[token_queue.size()-1].last = 1'b1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (token_queue.size() > 0 || in_tvalid || expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("postfix_expression_evaluator_unit_tb passed");
    end else begin
      $display("postfix_expression_evaluator_unit_tb failed");
    end
    $finish;
  end

endmodule
